@@ rtl/i2cseq_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared codes and types for the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	// Operation codes of an input beat
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_DONE  = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	// Transaction kinds
	localparam logic [1:0] KIND_WRITE     = 2'd0;
	localparam logic [1:0] KIND_REG_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ      = 2'd2;
	localparam logic [1:0] KIND_REG_READ  = 2'd3;

	// Engine commands
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_SEND  = 3'd2;
	localparam logic [2:0] CMD_RACK  = 3'd3;
	localparam logic [2:0] CMD_RNACK = 3'd4;
	localparam logic [2:0] CMD_STOP  = 3'd5;
	localparam logic [2:0] CMD_RESET = 3'd6;

	// Outcomes
	localparam logic [1:0] OUT_OK      = 2'd0;
	localparam logic [1:0] OUT_TIMEOUT = 2'd1;
	localparam logic [1:0] OUT_STATUS  = 2'd2;

	// Engine status codes (prescaler bits masked off)
	localparam logic [7:0] STATUS_MASK   = 8'hF8;
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RSTART     = 8'h10;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_RECV_ACK   = 8'h50;
	localparam logic [7:0] ST_RECV_NACK  = 8'h58;
	localparam logic       ADDR_READ_BIT = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT      = 2'd0;
	localparam logic [1:0] CFG_IGNORE_WRERR = 2'd1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] send_value;
		logic [7:0] read_data;
		logic       read_valid;
		logic       finished;
		logic [1:0] outcome;
		logic [7:0] offending_status;
	} result_t;

endpackage

@@ rtl/i2c_master_transaction_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Sequences one I2C master transaction at a time over a byte-level engine.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one beat per event: begin a
// transaction, engine done, stop finished or millisecond tick. Each beat
// yields exactly one result beat on the output channel (out_valid /
// out_stall) with the engine command to issue, any received byte, the
// finish flag and outcome, and the running lockup count.
// From input acceptance to out_valid a beat passes an input register, then
// the sequencing logic and the result register. One beat is accepted every
// cycle while the output is not stalled; the phase and counters update as
// the beat moves from the input register into the result register.
// When the receiver stalls, the result register holds, the input register
// fills, and in_stall rises until the result is taken.
// The configuration channel (cfg_valid / cfg_ready, always ready) writes
// timeout_ticks (index 0) and ignore_write_errors (index 1); other indexes
// are dropped. Write it only while no transaction beat is in flight.
// Reset returns the sequencer to idle, clears all counters and loads the
// configuration defaults (timeout 100 ticks, write errors counted).
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [1:0]  kind,
	input  logic [6:0]  device_address,
	input  logic [7:0]  register_index,
	input  logic [7:0]  byte_count,
	input  logic [7:0]  engine_status,
	input  logic [7:0]  received_byte,
	input  logic [7:0]  payload_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  command,
	output logic [7:0]  send_value,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        finished,
	output logic [1:0]  outcome,
	output logic [7:0]  offending_status,
	output logic [7:0]  lockups
);
	import i2cseq_pkg::*;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_START  = 4'd1;
	localparam logic [3:0] PH_ADDR_W = 4'd2;
	localparam logic [3:0] PH_REG    = 4'd3;
	localparam logic [3:0] PH_RSTART = 4'd4;
	localparam logic [3:0] PH_ADDR_R = 4'd5;
	localparam logic [3:0] PH_DATA_W = 4'd6;
	localparam logic [3:0] PH_RECV   = 4'd7;
	localparam logic [3:0] PH_STOP   = 4'd8;

	localparam int WideBits = (COUNT_BITS > 8) ? COUNT_BITS : 8;

	// configuration
	logic [15:0] timeout_q;
	logic        ignore_q;

	// sequencer state
	logic [3:0]            phase_q, phase_n;
	logic [1:0]            kind_q, kind_n;
	logic [6:0]            addr_q, addr_n;
	logic [7:0]            reg_q, reg_n;
	logic [7:0]            left_q, left_n;
	logic [15:0]           wait_q, wait_n;
	logic [COUNT_BITS-1:0] lock_q, lock_n;

	// input register
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [1:0] kind_s1;
	logic [6:0] addr_s1;
	logic [7:0] reg_s1;
	logic [7:0] count_s1;
	logic [7:0] st_s1;
	logic [7:0] rx_s1;
	logic [7:0] pay_s1;

	// result register
	logic                  valid_s2;
	result_t               res_s2;
	logic [COUNT_BITS-1:0] lock_s2;

	result_t     res;
	logic        advance;
	logic        do_fail;
	logic [1:0]  fail_why;
	logic [1:0]  lock_inc;
	logic [15:0] wait_inc;
	logic [WideBits-1:0] lock_wide;

	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			ignore_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIMEOUT:      timeout_q <= cfg_data;
				CFG_IGNORE_WRERR: ignore_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= operation;
			kind_s1  <= kind;
			addr_s1  <= device_address;
			reg_s1   <= register_index;
			count_s1 <= byte_count;
			st_s1    <= engine_status & STATUS_MASK;
			rx_s1    <= received_byte;
			pay_s1   <= payload_byte;
		end
	end

	// sequencing logic
	always_comb begin
		phase_n  = phase_q;
		kind_n   = kind_q;
		addr_n   = addr_q;
		reg_n    = reg_q;
		left_n   = left_q;
		wait_n   = wait_q;
		res      = '0;
		do_fail  = 1'b0;
		fail_why = OUT_OK;
		wait_inc = (wait_q < WAIT_MAX) ? wait_q + 16'd1 : wait_q;

		case (op_s1)
			OP_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					kind_n  = kind_s1;
					addr_n  = addr_s1;
					reg_n   = reg_s1;
					left_n  = (kind_s1[1] && count_s1 == 8'd0) ? 8'd1 : count_s1;
					res.command = CMD_START;
					wait_n  = '0;
					phase_n = PH_START;
				end
			end
			OP_DONE: begin
				case (phase_q)
					PH_START, PH_RSTART: begin
						if (!(st_s1 inside {ST_START, ST_RSTART})) begin
							do_fail  = 1'b1;
							fail_why = OUT_STATUS;
						end else if (phase_q == PH_RSTART || kind_q == KIND_READ) begin
							res.command    = CMD_SEND;
							res.send_value = {addr_q, ADDR_READ_BIT};
							wait_n         = '0;
							phase_n        = PH_ADDR_R;
						end else begin
							res.command    = CMD_SEND;
							res.send_value = {addr_q, 1'b0};
							wait_n         = '0;
							phase_n        = PH_ADDR_W;
						end
					end
					PH_ADDR_W, PH_REG, PH_DATA_W: begin
						// address status is not checked
						if (phase_q != PH_ADDR_W && st_s1 != ST_DATA_ACK) begin
							do_fail  = 1'b1;
							fail_why = OUT_STATUS;
						end else if (phase_q == PH_ADDR_W && kind_q != KIND_WRITE) begin
							res.command    = CMD_SEND;
							res.send_value = reg_q;
							wait_n         = '0;
							phase_n        = PH_REG;
						end else if (phase_q == PH_REG && kind_q == KIND_REG_READ) begin
							res.command = CMD_START;
							wait_n      = '0;
							phase_n     = PH_RSTART;
						end else if (left_q != 8'd0) begin
							res.command    = CMD_SEND;
							res.send_value = pay_s1;
							left_n         = left_q - 8'd1;
							wait_n         = '0;
							phase_n        = PH_DATA_W;
						end else begin
							res.command = CMD_STOP;
							wait_n      = '0;
							phase_n     = PH_STOP;
						end
					end
					PH_ADDR_R: begin
						res.command = (left_q == 8'd1) ? CMD_RNACK : CMD_RACK;
						wait_n      = '0;
						phase_n     = PH_RECV;
					end
					PH_RECV: begin
						if (st_s1 != ((left_q == 8'd1) ? ST_RECV_NACK : ST_RECV_ACK)) begin
							do_fail  = 1'b1;
							fail_why = OUT_STATUS;
						end else begin
							res.read_data  = rx_s1;
							res.read_valid = 1'b1;
							left_n         = left_q - 8'd1;
							wait_n         = '0;
							if (left_q == 8'd1) begin
								res.command = CMD_STOP;
								phase_n     = PH_STOP;
							end else begin
								// next byte is last when two remain now
								res.command = (left_q == 8'd2) ? CMD_RNACK : CMD_RACK;
								phase_n     = PH_RECV;
							end
						end
					end
					default: ;
				endcase
			end
			OP_STOP: begin
				if (phase_q == PH_STOP) begin
					res.finished = 1'b1;
					phase_n      = PH_IDLE;
					wait_n       = '0;
				end
			end
			default: begin
				if (phase_q != PH_IDLE && timeout_q != 16'd0) begin
					wait_n = wait_inc;
					if (wait_inc >= timeout_q) begin
						do_fail  = 1'b1;
						fail_why = OUT_TIMEOUT;
					end
				end
			end
		endcase

		// abort without a stop; a timeout also resets the engine
		lock_inc = 2'd0;
		if (do_fail) begin
			res.finished = 1'b1;
			res.outcome  = fail_why;
			phase_n      = PH_IDLE;
			wait_n       = '0;
			if (fail_why == OUT_TIMEOUT) begin
				res.command = CMD_RESET;
				lock_inc    = 2'd1;
			end else begin
				res.offending_status = st_s1;
			end
			if (!(kind_q == KIND_REG_WRITE && ignore_q)) begin
				lock_inc = lock_inc + 2'd1;
			end
		end
		lock_n = lock_q + COUNT_BITS'(lock_inc);
	end

	// sequencer state advances with each beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= '0;
			addr_q  <= '0;
			reg_q   <= '0;
			left_q  <= '0;
			wait_q  <= '0;
			lock_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			addr_q  <= addr_n;
			reg_q   <= reg_n;
			left_q  <= left_n;
			wait_q  <= wait_n;
			lock_q  <= lock_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= res;
			lock_s2 <= lock_n;
		end
	end

	assign lock_wide = WideBits'(lock_s2);

	assign out_valid        = valid_s2;
	assign command          = res_s2.command;
	assign send_value       = res_s2.send_value;
	assign read_data        = res_s2.read_data;
	assign read_valid       = res_s2.read_valid;
	assign finished         = res_s2.finished;
	assign outcome          = res_s2.outcome;
	assign offending_status = res_s2.offending_status;
	assign lockups          = lock_wide[7:0];

endmodule
